### sv/tcb_spline_basis_weight_defines.svh
// Assertion macros used by the spline basis weight checker
`ifndef TCB_SPLINE_BASIS_WEIGHT_DEFINES_SVH
`define TCB_SPLINE_BASIS_WEIGHT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define TCBSBW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcbsbw assertion failed");

// Implication delayed by the dly argument, disabled while reset is high
`define TCBSBW_ASSERT_DLY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("tcbsbw assertion failed");

`endif

### sv/tcbsbw_pkg.sv
// Types, widths and codes for the TCB spline basis weight block
package tcbsbw_pkg;

   localparam int FRAC_BITS = 14;
   localparam int WORK_FRAC = 28;
   localparam int T_FRAC    = 15;

   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int T_W       = 16;
   localparam int W_W       = 23;

   // internal widths, sized for any 16-bit register pattern
   localparam int S_W   = CFG_W + 1;
   localparam int Q_W   = 2 * S_W;
   localparam int SQ_W  = 34;
   localparam int E_W   = 38;
   localparam int ACC_W = 42;

   localparam int CFG_ONE = 2 ** (CFG_W - 2);
   localparam int LATENCY = 8;

   localparam logic [1:0] CMD_VALUE = 2'd0;
   localparam logic [1:0] CMD_SLOPE = 2'd1;
   localparam logic [1:0] CMD_CURVE = 2'd2;

   localparam logic [1:0] BASIS_PREV  = 2'd0;
   localparam logic [1:0] BASIS_START = 2'd1;
   localparam logic [1:0] BASIS_END   = 2'd2;
   localparam logic [1:0] BASIS_NEXT  = 2'd3;

   localparam logic [3:0] POINTS_CUBIC = 4'd4;

   localparam logic [CSR_IDX_W-1:0] REG_TENSION    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CONTINUITY = 2'd2;

   typedef struct packed {
      logic [1:0]     cmd;
      logic [1:0]     basis_index;
      logic [3:0]     point_count;
      logic [T_W-1:0] param_t;
   } req_type;

   typedef struct packed {
      logic signed [W_W-1:0] weight;
      logic                  saturated;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } ctl_type;

endpackage

### sv/tcb_spline_basis_weight.sv
// Kochanek-Bartels cubic basis weight: one request per clock, one strobe per request. The
// pipeline has eight register stages (request capture, config products, s*q, coefficient
// select, three Horner multiplies by t, round and clip) and the result port has no
// back-pressure, so busy is high only during reset.
// Tension, bias and continuity may change only while no request is in flight.
module tcb_spline_basis_weight (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  tcbsbw_pkg::req_type                  req_data,
   output logic                                 rsp_valid,
   output tcbsbw_pkg::rsp_type                  rsp_data,
   input  logic                                 csr_we,
   input  logic [tcbsbw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcbsbw_pkg::CFG_W-1:0]         csr_wdata
);
   import tcbsbw_pkg::*;

   localparam int RND_SH = WORK_FRAC - FRAC_BITS;
   localparam int SP_W   = S_W + Q_W;

   // configuration registers
   logic signed [CFG_W-1:0] tension_ff;
   logic signed [CFG_W-1:0] bias_ff;
   logic signed [CFG_W-1:0] continuity_ff;

   // request stage
   logic           accept;
   ctl_type        s1_ctl_in;
   ctl_type        s1_ctl_ff;
   logic [1:0]     s1_cmd_ff;
   logic [1:0]     s1_idx_ff;
   logic [T_W-1:0] s1_t_ff;

   // config products, aligned with the request stream
   logic signed [S_W-1:0] one_s;
   logic signed [S_W-1:0] s_in;
   logic signed [S_W-1:0] bp;
   logic signed [S_W-1:0] bm;
   logic signed [S_W-1:0] cp;
   logic signed [S_W-1:0] cm;
   logic signed [Q_W-1:0] q_in [4];
   logic signed [Q_W-1:0] q_ff [4];
   logic signed [S_W-1:0] s_ff;
   ctl_type               s2_ctl_ff;
   logic [1:0]            s2_cmd_ff;
   logic [1:0]            s2_idx_ff;
   logic [T_W-1:0]        s2_t_ff;

   logic signed [SP_W-1:0] sp     [4];
   logic signed [SP_W-1:0] sp_rnd [4];
   logic signed [SQ_W-1:0] sq_in  [4];
   logic signed [SQ_W-1:0] sq_ff  [4];
   ctl_type                s3_ctl_ff;
   logic [1:0]             s3_cmd_ff;
   logic [1:0]             s3_idx_ff;
   logic [T_W-1:0]         s3_t_ff;

   // coefficient stage
   logic signed [E_W-1:0] one_w;
   logic signed [E_W-1:0] x1, x2, x3, x4;
   logic signed [E_W-1:0] c3, c2, c1, c0;
   logic signed [E_W-1:0] e3_in, e2_in, e1_in, e0_in;
   logic signed [E_W-1:0] e3_ff, e2_ff, e1_ff, e0_ff;
   ctl_type               s4_ctl_ff;
   logic [T_W-1:0]        s4_t_ff;

   // Horner stages
   ctl_type                 h1_ctl;
   logic signed [ACC_W-1:0] h1_acc;
   logic signed [E_W-1:0]   s5_e1_ff, s5_e0_ff;
   logic [T_W-1:0]          s5_t_ff;
   ctl_type                 h2_ctl;
   logic signed [ACC_W-1:0] h2_acc;
   logic signed [E_W-1:0]   s6_e0_ff;
   logic [T_W-1:0]          s6_t_ff;
   ctl_type                 h3_ctl;
   logic signed [ACC_W-1:0] h3_acc;

   // output stage
   logic signed [ACC_W-1:0] w_full;
   rsp_type                 rsp_in;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff    <= CFG_W'(CFG_ONE);
         bias_ff       <= CFG_W'(CFG_ONE);
         continuity_ff <= CFG_W'(CFG_ONE);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TENSION:    tension_ff    <= csr_wdata;
            REG_BIAS:       bias_ff       <= csr_wdata;
            REG_CONTINUITY: continuity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: capture the request
   always_comb begin
      s1_ctl_in.valid = accept;
      s1_ctl_in.zero  = (req_data.point_count != POINTS_CUBIC) ||
                        !((req_data.cmd == CMD_VALUE) || (req_data.cmd == CMD_SLOPE) ||
                          (req_data.cmd == CMD_CURVE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff <= req_data.cmd;
      s1_idx_ff <= req_data.basis_index;
      s1_t_ff   <= req_data.param_t;
   end

   // Stage 2: s and the four q products, exact
   always_comb begin
      one_s   = S_W'(CFG_ONE);
      s_in    = one_s - S_W'(tension_ff);
      bp      = one_s + S_W'(bias_ff);
      bm      = one_s - S_W'(bias_ff);
      cp      = one_s + S_W'(continuity_ff);
      cm      = one_s - S_W'(continuity_ff);
      q_in[0] = Q_W'(bp) * Q_W'(cm);
      q_in[1] = Q_W'(bm) * Q_W'(cp);
      q_in[2] = Q_W'(bp) * Q_W'(cp);
      q_in[3] = Q_W'(bm) * Q_W'(cm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      q_ff      <= q_in;
      s2_cmd_ff <= s1_cmd_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_t_ff   <= s1_t_ff;
   end

   // Stage 3: s*q rounded to the working format
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sp[k]     = SP_W'(s_ff) * SP_W'(q_ff[k]);
         sp_rnd[k] = (sp[k] + SP_W'(2 ** (T_FRAC - 1))) >>> T_FRAC;
         sq_in[k]  = $signed(sp_rnd[k][SQ_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      s3_cmd_ff <= s2_cmd_ff;
      s3_idx_ff <= s2_idx_ff;
      s3_t_ff   <= s2_t_ff;
   end

   // Stage 4: cubic coefficients, then scale for the derivative order
   always_comb begin
      one_w = E_W'(2 ** WORK_FRAC);
      x1    = E_W'(sq_ff[0]);
      x2    = E_W'(sq_ff[1]);
      x3    = E_W'(sq_ff[2]);
      x4    = E_W'(sq_ff[3]);
      case (s3_idx_ff)
         BASIS_PREV: begin
            c3 = -x1;
            c2 = x1 <<< 1;
            c1 = -x1;
            c0 = '0;
         end
         BASIS_START: begin
            c3 = (one_w <<< 1) + x1 - x2 - x3;
            c2 = -((one_w <<< 1) + one_w) - (x1 <<< 1) + (x2 <<< 1) + x3;
            c1 = x1 - x2;
            c0 = one_w;
         end
         BASIS_END: begin
            c3 = -(one_w <<< 1) + x2 + x3 - x4;
            c2 = (one_w <<< 1) + one_w - (x2 <<< 1) - x3 + x4;
            c1 = x2;
            c0 = '0;
         end
         default: begin
            c3 = x4;
            c2 = -x4;
            c1 = '0;
            c0 = '0;
         end
      endcase
      case (s3_cmd_ff)
         CMD_VALUE: begin
            e3_in = c3;
            e2_in = c2;
            e1_in = c1;
            e0_in = c0;
         end
         CMD_SLOPE: begin
            e3_in = '0;
            e2_in = (c3 <<< 1) + c3;
            e1_in = c2 <<< 1;
            e0_in = c1;
         end
         default: begin
            e3_in = '0;
            e2_in = '0;
            e1_in = (c3 <<< 2) + (c3 <<< 1);
            e0_in = c2 <<< 1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else begin
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      e3_ff   <= e3_in;
      e2_ff   <= e2_in;
      e1_ff   <= e1_in;
      e0_ff   <= e0_in;
      s4_t_ff <= s3_t_ff;
   end

   // Stages 5 to 7: Horner's rule, one multiply by t per stage
   tcbsbw_horner u_horner1 (
      .clock   (clock),
      .reset   (reset),
      .ctl_src (s4_ctl_ff),
      .param_t (s4_t_ff),
      .acc_src (ACC_W'(e3_ff)),
      .addend  (e2_ff),
      .ctl_dst (h1_ctl),
      .acc_dst (h1_acc)
   );

   always_ff @(posedge clock) begin
      s5_e1_ff <= e1_ff;
      s5_e0_ff <= e0_ff;
      s5_t_ff  <= s4_t_ff;
   end

   tcbsbw_horner u_horner2 (
      .clock   (clock),
      .reset   (reset),
      .ctl_src (h1_ctl),
      .param_t (s5_t_ff),
      .acc_src (h1_acc),
      .addend  (s5_e1_ff),
      .ctl_dst (h2_ctl),
      .acc_dst (h2_acc)
   );

   always_ff @(posedge clock) begin
      s6_e0_ff <= s5_e0_ff;
      s6_t_ff  <= s5_t_ff;
   end

   tcbsbw_horner u_horner3 (
      .clock   (clock),
      .reset   (reset),
      .ctl_src (h2_ctl),
      .param_t (s6_t_ff),
      .acc_src (h2_acc),
      .addend  (s6_e0_ff),
      .ctl_dst (h3_ctl),
      .acc_dst (h3_acc)
   );

   // Stage 8: round to the output format and clip
   always_comb begin
      w_full = (h3_acc + ACC_W'(2 ** (RND_SH - 1))) >>> RND_SH;
      if (h3_ctl.zero) begin
         rsp_in.weight    = '0;
         rsp_in.saturated = 1'b0;
      end else if (w_full > ACC_W'(2 ** (W_W - 1) - 1)) begin
         rsp_in.weight    = W_W'(2 ** (W_W - 1) - 1);
         rsp_in.saturated = 1'b1;
      end else if (w_full < -ACC_W'(2 ** (W_W - 1))) begin
         rsp_in.weight    = W_W'(-(2 ** (W_W - 1)));
         rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.weight    = w_full[W_W-1:0];
         rsp_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= h3_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/tcbsbw_horner.sv
// One Horner step: acc * t rounded back to the working format, plus the next coefficient
module tcbsbw_horner (
   input  logic                                clock,
   input  logic                                reset,
   input  tcbsbw_pkg::ctl_type                 ctl_src,
   input  logic [tcbsbw_pkg::T_W-1:0]          param_t,
   input  logic signed [tcbsbw_pkg::ACC_W-1:0] acc_src,
   input  logic signed [tcbsbw_pkg::E_W-1:0]   addend,
   output tcbsbw_pkg::ctl_type                 ctl_dst,
   output logic signed [tcbsbw_pkg::ACC_W-1:0] acc_dst
);
   import tcbsbw_pkg::*;

   localparam int P_W = ACC_W + T_W + 1;

   logic signed [P_W-1:0]   prod;
   logic signed [P_W-1:0]   prod_rnd;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_ff;
   ctl_type                 ctl_ff;

   always_comb begin
      prod     = P_W'(acc_src) * P_W'($signed({1'b0, param_t}));
      // round to nearest, ties up
      prod_rnd = (prod + P_W'(2 ** (T_FRAC - 1))) >>> T_FRAC;
      acc_in   = $signed(prod_rnd[ACC_W-1:0]) + ACC_W'(addend);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_src;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign ctl_dst = ctl_ff;
   assign acc_dst = acc_ff;

endmodule

### sv/tcbsbw_checker.sv
// Port-level checks for the spline basis weight block and their bind
`include "tcb_spline_basis_weight_defines.svh"

module tcbsbw_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input tcbsbw_pkg::req_type req_data,
   input logic                rsp_valid,
   input tcbsbw_pkg::rsp_type rsp_data
);
   import tcbsbw_pkg::*;

   logic req_fire;
   logic req_odd_count;
   logic rsp_zero;
   logic rsp_limit;

   assign req_fire      = start && !busy;
   assign req_odd_count = req_fire && (req_data.point_count != POINTS_CUBIC);
   assign rsp_zero      = (rsp_data.weight == '0) && !rsp_data.saturated;
   assign rsp_limit     = (rsp_data.weight == W_W'(2 ** (W_W - 1) - 1)) ||
                          (rsp_data.weight == W_W'(-(2 ** (W_W - 1))));

   `TCBSBW_ASSERT_DLY(a_rsp_follows_req, clock, reset, req_fire, LATENCY, rsp_valid)

   `TCBSBW_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(req_fire, LATENCY))

   `TCBSBW_ASSERT_DLY(a_wrong_count_zero, clock, reset, req_odd_count, LATENCY, rsp_zero)

   `TCBSBW_ASSERT_IMP(a_sat_at_limit, clock, reset, rsp_valid && rsp_data.saturated, rsp_limit)

endmodule

bind tcb_spline_basis_weight tcbsbw_checker u_tcbsbw_checker (.*);

### bench/tcb_spline_basis_weight_tb.sv
// Self-checking bench for the TCB spline basis weight block: random and edge-case requests
module tcb_spline_basis_weight_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcbsbw_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam longint     W_HI     = (longint'(1) << (W_W - 1)) - 1;
   localparam longint     W_LO     = -(longint'(1) << (W_W - 1));
   localparam int         PHASES   = 12;
   localparam int         PER_PHASE = 54;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // shadow copy of the block's settings
   logic signed [CFG_W-1:0] tension_q;
   logic signed [CFG_W-1:0] bias_q;
   logic signed [CFG_W-1:0] continuity_q;

   req_type request_q[$];
   rsp_type weight_q[$];

   int  queued    = 0;
   int  checked   = 0;
   int  bad_count = 0;
   int  sat_seen  = 0;
   int  settings  = 1;
   int  gap_left  = 0;
   bit  calm      = 1'b0;

   tcb_spline_basis_weight dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #200us;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // floor((v + half) / 2^n): nearest, ties toward plus infinity
   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic rsp_type basis_weight(req_type r);
      longint one, t, s, bp, bm, cp, cm;
      longint sq1, sq2, sq3, sq4;
      longint c3, c2, c1, c0, e3, e2, e1, e0, acc, w;
      rsp_type o;
      o = '0;
      if (r.point_count != POINTS_CUBIC || r.cmd == CMD_NONE)
         return o;
      one = longint'(1) << WORK_FRAC;
      t   = longint'(r.param_t);
      s   = CFG_ONE - longint'(tension_q);
      bp  = CFG_ONE + longint'(bias_q);
      bm  = CFG_ONE - longint'(bias_q);
      cp  = CFG_ONE + longint'(continuity_q);
      cm  = CFG_ONE - longint'(continuity_q);
      sq1 = round_shift(s * (bp * cm), 15);
      sq2 = round_shift(s * (bm * cp), 15);
      sq3 = round_shift(s * (bp * cp), 15);
      sq4 = round_shift(s * (bm * cm), 15);
      case (r.basis_index)
         BASIS_PREV: begin
            c3 = -sq1; c2 = 2 * sq1; c1 = -sq1; c0 = 0;
         end
         BASIS_START: begin
            c3 = 2 * one + sq1 - sq2 - sq3;
            c2 = -3 * one - 2 * sq1 + 2 * sq2 + sq3;
            c1 = sq1 - sq2;
            c0 = one;
         end
         BASIS_END: begin
            c3 = -2 * one + sq2 + sq3 - sq4;
            c2 = 3 * one - 2 * sq2 - sq3 + sq4;
            c1 = sq2;
            c0 = 0;
         end
         default: begin
            c3 = sq4; c2 = -sq4; c1 = 0; c0 = 0;
         end
      endcase
      case (r.cmd)
         CMD_VALUE: begin
            e3 = c3; e2 = c2; e1 = c1; e0 = c0;
         end
         CMD_SLOPE: begin
            e3 = 0; e2 = 3 * c3; e1 = 2 * c2; e0 = c1;
         end
         default: begin
            e3 = 0; e2 = 0; e1 = 6 * c3; e0 = 2 * c2;
         end
      endcase
      acc = e3;
      acc = round_shift(acc * t, T_FRAC) + e2;
      acc = round_shift(acc * t, T_FRAC) + e1;
      acc = round_shift(acc * t, T_FRAC) + e0;
      w = round_shift(acc, WORK_FRAC - FRAC_BITS);
      if (w > W_HI) begin
         w = W_HI;
         o.saturated = 1'b1;
      end else if (w < W_LO) begin
         w = W_LO;
         o.saturated = 1'b1;
      end
      o.weight = w[W_W-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tension_q    <= CFG_W'(CFG_ONE);
         bias_q       <= CFG_W'(CFG_ONE);
         continuity_q <= CFG_W'(CFG_ONE);
      end else if (csr_we) begin
         case (csr_index)
            REG_TENSION:    tension_q    <= csr_wdata;
            REG_BIAS:       bias_q       <= csr_wdata;
            REG_CONTINUITY: continuity_q <= csr_wdata;
            default: ;
         endcase
      end
   end

   // driver: present pending requests, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            weight_q.push_back(basis_weight(req_data));
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               start    <= 1'b0;
               gap_left = gap_left - 1;
            end else if (!calm && request_q.size() != 0 && $urandom_range(0, 5) == 0) begin
               start    <= 1'b0;
               gap_left = $urandom_range(0, 2);
            end else if (request_q.size() != 0) begin
               req_data <= request_q.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe retires the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (weight_q.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
               $display("unexpected result: weight %0d sat %0b",
                        rsp_data.weight, rsp_data.saturated);
         end else begin
            want = weight_q.pop_front();
            if (rsp_data.weight !== want.weight || rsp_data.saturated !== want.saturated) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("result %0d: expected weight %0d sat %0b, got weight %0d sat %0b",
                           checked, want.weight, want.saturated,
                           rsp_data.weight, rsp_data.saturated);
            end
            if (rsp_data.saturated)
               sat_seen++;
         end
         checked++;
      end
   end

   task automatic push_item(logic [1:0] cmd, logic [1:0] basis, logic [3:0] count,
                            logic [T_W-1:0] t);
      req_type r;
      r.cmd         = cmd;
      r.basis_index = basis;
      r.point_count = count;
      r.param_t     = t;
      request_q.push_back(r);
      queued++;
   endtask

   task automatic push_random();
      logic [1:0]     cmd;
      logic [3:0]     count;
      logic [T_W-1:0] t;
      cmd   = ($urandom_range(0, 9) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
      count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : POINTS_CUBIC;
      case ($urandom_range(0, 9))
         0:       t = 16'($urandom);
         1:       t = $urandom_range(0, 1) ? 16'd32768 : 16'd0;
         default: t = 16'($urandom_range(0, 32768));
      endcase
      push_item(cmd, 2'($urandom_range(0, 3)), count, t);
   endtask

   function automatic logic [CFG_W-1:0] pick_setting();
      if ($urandom_range(0, 4) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   // drain every outstanding request, then let the pipeline empty
   task automatic settle();
      while (checked != queued)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic load_settings(logic [CFG_W-1:0] t, logic [CFG_W-1:0] b,
                                logic [CFG_W-1:0] c);
      settle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_TENSION;
      csr_wdata <= t;
      @(posedge clock);
      csr_index <= REG_BIAS;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= REG_CONTINUITY;
      csr_wdata <= c;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings++;
   endtask

   initial begin
      logic [CFG_W-1:0] fixed_t[5] = '{16'hC000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000};
      logic [CFG_W-1:0] fixed_b[5] = '{16'hC000, 16'hC000, 16'h4000, 16'h8000, 16'h7FFF};
      logic [CFG_W-1:0] fixed_c[5] = '{16'hC000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings leave s at zero
      repeat (10) push_random();

      // Catmull-Rom settings: every operation and basis, field extremes
      load_settings(16'h0000, 16'h0000, 16'h0000);
      for (int c = 0; c < 3; c++)
         for (int b = 0; b < 4; b++)
            push_item(2'(c), 2'(b), POINTS_CUBIC, (b == 0) ? 16'd0 :
                      (b == 1) ? 16'd32768 : (b == 2) ? 16'd16384 : 16'd65535);
      push_item(CMD_NONE, BASIS_START, POINTS_CUBIC, 16'd32768);
      push_item(CMD_VALUE, BASIS_START, 4'd0, 16'd16384);
      push_item(CMD_VALUE, BASIS_START, 4'd15, 16'd16384);
      push_item(CMD_VALUE, BASIS_START, 4'd3, 16'd16384);
      push_item(CMD_VALUE, BASIS_START, 4'd5, 16'd16384);
      push_item(CMD_SLOPE, BASIS_END, 4'd8, 16'd16384);
      for (int b = 0; b < 4; b++)
         push_item(CMD_CURVE, 2'(b), POINTS_CUBIC, 16'd65535);
      push_item(CMD_VALUE, BASIS_END, POINTS_CUBIC, 16'd1);

      for (int p = 0; p < PHASES; p++) begin
         if (p < 5)
            load_settings(fixed_t[p], fixed_b[p], fixed_c[p]);
         else
            load_settings(pick_setting(), pick_setting(), pick_setting());
         if (p >= PHASES - 2)
            calm = 1'b1;
         repeat (PER_PHASE) push_random();
      end

      settle();
      if (weight_q.size() != 0)
         bad_count += weight_q.size();
      $display("checked %0d weights over %0d register settings, %0d of them clipped",
               checked, settings, sat_seen);
      $display("%0d mismatches in total", bad_count);
      if (bad_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/tcbsbw_pkg.sv
sv/tcbsbw_horner.sv
sv/tcb_spline_basis_weight.sv
sv/tcbsbw_checker.sv
bench/tcb_spline_basis_weight_tb.sv
